// ===== sv/eat_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package eat_pkg;

   // Field widths
   localparam int CNT_W  = 31;
   localparam int TIME_W = 32;
   localparam int THR_W  = 10;
   localparam int DEN_W  = 27;
   localparam int OP_W   = TIME_W + 2;
   localparam int BIT_W  = 5;

   // Packed result width, rounded up to whole bytes
   localparam int RSP_RAW_W = 1 + 4 * CNT_W + 4 * TIME_W;
   localparam int RSP_W     = ((RSP_RAW_W + 7) / 8) * 8;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
   localparam logic [THR_W-1:0] THR_DEFAULT = THR_W'(2);

   // Time windows in seconds
   localparam logic [OP_W-1:0] STALE_SECS = OP_W'(800);
   localparam logic [OP_W-1:0] LONG_SECS  = OP_W'(7200);
   localparam logic [OP_W-1:0] SHORT_SECS = OP_W'(3600);
   localparam logic [OP_W-1:0] QUIET_SECS = OP_W'(240);

   // Count levels that widen the backoff divisor
   localparam logic [CNT_W-1:0] LVL_100  = CNT_W'(99);
   localparam logic [CNT_W-1:0] LVL_1K   = CNT_W'(999);
   localparam logic [CNT_W-1:0] LVL_BIG  = CNT_W'(9999);
   localparam logic [CNT_W-1:0] POW_6    = CNT_W'(1000000);
   localparam logic [CNT_W-1:0] POW_7    = CNT_W'(10000000);
   localparam logic [CNT_W-1:0] POW_8    = CNT_W'(100000000);
   localparam logic [CNT_W-1:0] POW_9    = CNT_W'(1000000000);

   localparam logic [DEN_W-1:0] DEN_10  = DEN_W'(10);
   localparam logic [DEN_W-1:0] DEN_1E2 = DEN_W'(100);
   localparam logic [DEN_W-1:0] DEN_1E3 = DEN_W'(1000);
   localparam logic [DEN_W-1:0] DEN_1E4 = DEN_W'(10000);
   localparam logic [DEN_W-1:0] DEN_1E5 = DEN_W'(100000);
   localparam logic [DEN_W-1:0] DEN_1E6 = DEN_W'(1000000);
   localparam logic [DEN_W-1:0] DEN_1E7 = DEN_W'(10000000);
   localparam logic [DEN_W-1:0] DEN_1E8 = DEN_W'(100000000);

   // Saturating increment
   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
   endfunction

endpackage

`default_nettype wire

// ===== sv/event_alert_throttle_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Alert throttle for one event rule. Each request item is one event (req_tuser = 1 for a
// hit, 0 for a miss) stamped with the time in seconds on req_tdata; each event gives one
// response item with the alert flag, the four counters after the update and the four time
// stamps. A hit runs the time window checks and the restoring remainder loop (one bit of
// the 31-bit recent count per cycle), all of which share a single 34-bit subtractor; a
// miss skips both. The block takes no new event until the current one has been placed in
// the response register, which holds a finished item while the next event is accepted.
// csr_we writes the hit threshold; the user is to use it only while the block is idle,
// which the block itself does not enforce. 0 selects the default of 2.
module event_alert_throttle_top (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_we,
   input  wire  [eat_pkg::THR_W-1:0]        csr_wdata,   // hit_threshold
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [eat_pkg::TIME_W-1:0]       req_tdata,   // now_seconds
   input  wire                              req_tuser,   // is_hit
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // rsp_tdata, lowest bit up: alert, recent_hits, total_hits, recent_misses,
   // total_misses, first_event_time, first_hit_time, last_hit_time,
   // prior_alert_time, zero padding
   output logic [eat_pkg::RSP_W-1:0]        rsp_tdata
);
   import eat_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_UPDATE = 3'd1;
   localparam logic [2:0] ST_LONG   = 3'd2;
   localparam logic [2:0] ST_SHORT  = 3'd3;
   localparam logic [2:0] ST_QUIET  = 3'd4;
   localparam logic [2:0] ST_DENOM  = 3'd5;
   localparam logic [2:0] ST_MOD    = 3'd6;
   localparam logic [2:0] ST_DONE   = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [THR_W-1:0]  thr_ff;
   logic              hit_ff;
   logic [TIME_W-1:0] now_ff;

   logic [CNT_W-1:0]  rhit_ff, rhit_in;
   logic [CNT_W-1:0]  thit_ff, thit_in;
   logic [CNT_W-1:0]  rmiss_ff, rmiss_in;
   logic [CNT_W-1:0]  tmiss_ff, tmiss_in;
   logic [TIME_W-1:0] first_ff, first_in;
   logic [TIME_W-1:0] fhit_ff, fhit_in;
   logic [TIME_W-1:0] lhit_ff, lhit_in;
   logic [TIME_W-1:0] lalert_ff, lalert_in;

   logic              long_ok_ff, short_ok_ff, quiet_ff;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [BIT_W-1:0]  bit_ff;

   logic              rsp_valid_ff;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   logic [OP_W-1:0]   op_a, op_b, diff;
   logic              ge;
   logic [DEN_W:0]    shifted;
   logic              stale;
   logic [THR_W-1:0]  thr_eff;
   logic              alert;
   logic              out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Shared subtractor: window checks and the remainder loop
   assign shifted = {rem_ff, rhit_ff[bit_ff]};
   always_comb begin
      op_a = '0;
      op_b = {2'b00, now_ff};
      unique case (state_ff)
         ST_UPDATE: op_a = {2'b00, lhit_ff} + STALE_SECS;
         ST_LONG:   op_a = {2'b00, lalert_ff} + LONG_SECS;
         ST_SHORT:  op_a = {2'b00, lalert_ff} + SHORT_SECS;
         ST_QUIET:  op_a = {2'b00, lalert_ff} + QUIET_SECS;
         ST_MOD: begin
            op_a = OP_W'(shifted);
            op_b = OP_W'(den_ff);
         end
         default: op_a = '0;
      endcase
   end
   assign diff = op_a - op_b;
   assign ge   = !diff[OP_W-1];

   // Counter and stamp update for the accepted event
   assign stale = hit_ff && !ge;
   always_comb begin
      rhit_in  = rhit_ff;
      thit_in  = thit_ff;
      rmiss_in = rmiss_ff;
      tmiss_in = tmiss_ff;
      first_in = first_ff;
      fhit_in  = fhit_ff;
      lhit_in  = lhit_ff;
      if (thit_ff == '0 && tmiss_ff == '0) begin
         first_in = now_ff;
      end
      if (hit_ff) begin
         if (thit_ff == '0) begin
            fhit_in = now_ff;
         end
         thit_in  = sat_inc(thit_ff);
         rhit_in  = stale ? CNT_W'(1) : sat_inc(rhit_ff);
         rmiss_in = stale ? '0 : rmiss_ff;
         lhit_in  = now_ff;
      end else begin
         rmiss_in = sat_inc(rmiss_ff);
         tmiss_in = sat_inc(tmiss_ff);
      end
   end

   // Backoff divisor from the recent count and the alert windows
   always_comb begin
      den_in = DEN_10;
      if (rhit_ff >= LVL_100 && long_ok_ff) begin
         den_in = DEN_1E2;
         if (rhit_ff >= LVL_1K && short_ok_ff) begin
            den_in = DEN_1E3;
            if (rhit_ff >= LVL_BIG) begin
               if (rhit_ff >= POW_9) begin
                  den_in = DEN_1E8;
               end else if (rhit_ff >= POW_8) begin
                  den_in = DEN_1E7;
               end else if (rhit_ff >= POW_7) begin
                  den_in = DEN_1E6;
               end else if (rhit_ff >= POW_6) begin
                  den_in = DEN_1E5;
               end else begin
                  den_in = DEN_1E4;
               end
            end
         end
      end
   end

   // Restoring remainder step
   assign rem_in = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];

   // Alert decision and packed result
   assign thr_eff = (thr_ff == '0) ? THR_DEFAULT : thr_ff;
   always_comb begin
      alert = 1'b0;
      if (hit_ff) begin
         if (rhit_ff == CNT_W'(thr_eff)) begin
            alert = 1'b1;
         end else if (rhit_ff > CNT_W'(thr_eff) && rem_ff == '0 && quiet_ff) begin
            alert = 1'b1;
         end
      end
      lalert_in   = alert ? now_ff : lalert_ff;
      rsp_data_in = RSP_W'({lalert_ff, lhit_ff, fhit_ff, first_ff,
                            tmiss_ff, rmiss_ff, thit_ff, rhit_ff, alert});
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_tvalid) state_in = ST_UPDATE;
         ST_UPDATE: state_in = hit_ff ? ST_LONG : ST_DONE;
         ST_LONG:   state_in = ST_SHORT;
         ST_SHORT:  state_in = ST_QUIET;
         ST_QUIET:  state_in = ST_DENOM;
         ST_DENOM:  state_in = ST_MOD;
         ST_MOD:    if (bit_ff == '0) state_in = ST_DONE;
         ST_DONE:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rhit_ff      <= '0;
         thit_ff      <= '0;
         rmiss_ff     <= '0;
         tmiss_ff     <= '0;
         first_ff     <= '0;
         fhit_ff      <= '0;
         lhit_ff      <= '0;
         lalert_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            thr_ff <= csr_wdata;
         end
         // load a new response when done, else drop the one taken
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
            lalert_ff    <= lalert_in;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_UPDATE) begin
            rhit_ff  <= rhit_in;
            thit_ff  <= thit_in;
            rmiss_ff <= rmiss_in;
            tmiss_ff <= tmiss_in;
            first_ff <= first_in;
            fhit_ff  <= fhit_in;
            lhit_ff  <= lhit_in;
         end
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_tvalid) begin
         hit_ff <= req_tuser;
         now_ff <= req_tdata;
      end
      if (state_ff == ST_LONG) begin
         long_ok_ff <= ge;
      end
      if (state_ff == ST_SHORT) begin
         short_ok_ff <= ge;
      end
      if (state_ff == ST_QUIET) begin
         quiet_ff <= !ge;
      end
      if (state_ff == ST_DENOM) begin
         den_ff <= den_in;
         rem_ff <= '0;
         bit_ff <= BIT_W'(CNT_W - 1);
      end
      if (state_ff == ST_MOD) begin
         rem_ff <= rem_in;
         bit_ff <= bit_ff - BIT_W'(1);
      end
      if (state_ff == ST_DONE && out_free) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

// ===== test/event_alert_throttle_top_tb.sv =====
`timescale 1ns / 1ps

module event_alert_throttle_top_tb;

   import eat_pkg::*;

   localparam logic KIND_MISS = 1'b0;
   localparam logic KIND_HIT  = 1'b1;

   localparam int LATENCY_CYCLES = 40;
   localparam int HOLD_CYCLES    = 400;
   localparam int STALL_LIMIT    = 4000;

   // Field offsets inside rsp_tdata
   localparam int OFF_RH = 1;
   localparam int OFF_TH = OFF_RH + CNT_W;
   localparam int OFF_RM = OFF_TH + CNT_W;
   localparam int OFF_TM = OFF_RM + CNT_W;
   localparam int OFF_FE = OFF_TM + CNT_W;
   localparam int OFF_FH = OFF_FE + TIME_W;
   localparam int OFF_LH = OFF_FH + TIME_W;
   localparam int OFF_PA = OFF_LH + TIME_W;

   typedef struct {
      logic              alert;
      logic [CNT_W-1:0]  recent_hits;
      logic [CNT_W-1:0]  total_hits;
      logic [CNT_W-1:0]  recent_misses;
      logic [CNT_W-1:0]  total_misses;
      logic [TIME_W-1:0] first_event_time;
      logic [TIME_W-1:0] first_hit_time;
      logic [TIME_W-1:0] last_hit_time;
      logic [TIME_W-1:0] prior_alert_time;
   } alert_report_type;

   logic              clock;
   logic              reset      = 1'b1;
   logic              csr_we     = 1'b0;
   logic [THR_W-1:0]  csr_wdata  = '0;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [TIME_W-1:0] req_tdata  = '0;
   logic              req_tuser  = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;

   // Throttle state as the block should hold it
   logic [THR_W-1:0]  thr_setting;
   logic [CNT_W-1:0]  hits_recent, hits_total, misses_window, misses_total;
   logic [TIME_W-1:0] seen_first_at, hit_first_at, hit_last_at, alert_last_at;

   alert_report_type reports_due[$];
   int            mismatches  = 0;
   int            quiet_cycles = 0;
   bit            gaps_on     = 1'b1;
   bit            hold_off    = 1'b0;

   event_alert_throttle_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
      return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
   endfunction

   // Advance the throttle state by one item and return the report it gives
   function automatic alert_report_type account_event(input logic kind,
                                                       input logic [TIME_W-1:0] now);
      alert_report_type  rep;
      longint unsigned   t, thr_eff, divisor, r, v;
      int                digits;
      t = now;
      rep.alert = 1'b0;
      rep.prior_alert_time = alert_last_at;
      // a hit after a long quiet spell starts a fresh recent window
      if (kind == KIND_HIT && t > 64'(hit_last_at) + 800) begin
         hits_recent   = '0;
         misses_window = '0;
      end
      if (hits_total == '0 && misses_total == '0)
         seen_first_at = now;
      if (kind == KIND_HIT) begin
         thr_eff = (thr_setting == '0) ? 2 : 64'(thr_setting);
         if (hits_total == '0)
            hit_first_at = now;
         hits_total  = count_up(hits_total);
         hits_recent = count_up(hits_recent);
         hit_last_at = now;
         r = hits_recent;
         // widen the backoff divisor while alerts are recent
         divisor = 10;
         if (r >= 99 && 64'(alert_last_at) + 7200 >= t) begin
            divisor = 100;
            if (r >= 999 && 64'(alert_last_at) + 3600 >= t) begin
               divisor = 1000;
               if (r >= 9999) begin
                  digits = 0;
                  v = r;
                  while (v > 0) begin
                     v = v / 10;
                     digits++;
                  end
                  if (digits < 6) begin
                     divisor = 10000;
                  end else begin
                     if (digits > 10)
                        digits = 10;
                     divisor = 1;
                     for (int i = 0; i + 2 < digits; i++)
                        divisor = divisor * 10;
                  end
               end
            end
         end
         if (r == thr_eff ||
             (r > thr_eff && (r % divisor) == 0 && 64'(alert_last_at) + 240 < t))
            rep.alert = 1'b1;
         if (rep.alert)
            alert_last_at = now;
      end else begin
         misses_window = count_up(misses_window);
         misses_total  = count_up(misses_total);
      end
      rep.recent_hits      = hits_recent;
      rep.total_hits       = hits_total;
      rep.recent_misses    = misses_window;
      rep.total_misses     = misses_total;
      rep.first_event_time = seen_first_at;
      rep.first_hit_time   = hit_first_at;
      rep.last_hit_time    = hit_last_at;
      return rep;
   endfunction

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // Check each response item, track register writes, predict each accepted item
   always @(posedge clock) begin : scoreboard
      alert_report_type want;
      if (reset) begin
         thr_setting   = '0;
         hits_recent   = '0;
         hits_total    = '0;
         misses_window = '0;
         misses_total  = '0;
         seen_first_at = '0;
         hit_first_at  = '0;
         hit_last_at   = '0;
         alert_last_at = '0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (reports_due.size() == 0) begin
               $error("response item with no event outstanding");
               mismatches++;
            end else begin
               want = reports_due.pop_front();
               check_field("alert", want.alert, rsp_tdata[0]);
               check_field("recent_hits", want.recent_hits, rsp_tdata[OFF_RH +: CNT_W]);
               check_field("total_hits", want.total_hits, rsp_tdata[OFF_TH +: CNT_W]);
               check_field("recent_misses", want.recent_misses,
                           rsp_tdata[OFF_RM +: CNT_W]);
               check_field("total_misses", want.total_misses, rsp_tdata[OFF_TM +: CNT_W]);
               check_field("first_event_time", want.first_event_time,
                           rsp_tdata[OFF_FE +: TIME_W]);
               check_field("first_hit_time", want.first_hit_time,
                           rsp_tdata[OFF_FH +: TIME_W]);
               check_field("last_hit_time", want.last_hit_time,
                           rsp_tdata[OFF_LH +: TIME_W]);
               check_field("prior_alert_time", want.prior_alert_time,
                           rsp_tdata[OFF_PA +: TIME_W]);
            end
         end
         if (csr_we)
            thr_setting = csr_wdata;
         if (req_tvalid && req_tready)
            reports_due.push_back(account_event(req_tuser, req_tdata));
      end
   end

   // Drop the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("event_alert_throttle_top regression: fail");
         $finish;
      end
   end

   // Response side: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off = 1'b0;
            rsp_tready <= 1'b1;
         end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Offer one item and hold it until it is taken
   task automatic send_event(input logic kind, input logic [TIME_W-1:0] stamp);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= stamp;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Write the threshold once every outstanding item has come back
   task automatic set_threshold(input logic [THR_W-1:0] value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (reports_due.size() != 0) @(posedge clock);
      repeat (LATENCY_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Time extremes, wrap-free sums, stale clearing and the first-event stamps
   task automatic test_edge_events();
      send_event(KIND_MISS, 32'h0000_0000);
      send_event(KIND_MISS, 32'hFFFF_FFFF);
      send_event(KIND_HIT, 32'h0000_0000);
      send_event(KIND_HIT, 32'd800);
      send_event(KIND_HIT, 32'd1601);
      send_event(KIND_HIT, 32'hFFFF_FFFF);
      send_event(KIND_HIT, 32'hFFFF_FFFF);
      send_event(KIND_HIT, 32'h0000_0000);
      send_event(KIND_MISS, 32'd7);
      // last alert near the top of the range: no backoff alert can follow
      repeat (7) send_event(KIND_HIT, 32'd5);
      send_event(KIND_HIT, 32'h8000_0000);
      send_event(KIND_HIT, 32'h8000_0001);
   endtask

   // Hold the response side off while items keep coming, so the block stalls
   task automatic test_response_backpressure();
      logic [TIME_W-1:0] stamp;
      stamp = $urandom();
      gaps_on  = 1'b0;
      hold_off = 1'b1;
      for (int i = 0; i < 8; i++) begin
         stamp = stamp + 1;
         send_event(i % 3 == 2 ? KIND_MISS : KIND_HIT, stamp);
      end
      while (hold_off) @(posedge clock);
      gaps_on = 1'b1;
   endtask

   // Bursts of events with one time profile per burst
   task automatic run_sessions(input int n_items, input bit allow_gaps);
      logic [TIME_W-1:0] stamp;
      logic              kind;
      int                sent, len, profile;
      sent  = 0;
      stamp = $urandom();
      while (sent < n_items) begin
         profile = $urandom_range(0, 4);
         len     = $urandom_range(10, 250);
         gaps_on = allow_gaps && ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 3) == 0)
            stamp = $urandom();
         for (int i = 0; i < len && sent < n_items; i++) begin
            case (profile)
               0: stamp = stamp + $urandom_range(0, 3);
               1: stamp = stamp + $urandom_range(60, 790);
               2: stamp = stamp + $urandom_range(0, 1000);
               3: stamp = $urandom();
               default: stamp = stamp + $urandom_range(200, 300);
            endcase
            kind = ($urandom_range(0, 4) != 0) ? KIND_HIT : KIND_MISS;
            send_event(kind, stamp);
            sent++;
         end
      end
   endtask

   // Dense hits long enough to walk the divisor up to a hundred
   task automatic test_deep_backoff();
      logic [TIME_W-1:0] stamp;
      int                hits;
      gaps_on = 1'b0;
      stamp   = $urandom_range(0, 32'h7FFF_FFFF);
      hits    = 0;
      while (hits < 150) begin
         if ($urandom_range(0, 15) == 0) begin
            send_event(KIND_MISS, stamp);
         end else begin
            stamp = stamp + $urandom_range(0, 1);
            send_event(KIND_HIT, stamp);
            hits++;
         end
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_edge_events();
      set_threshold(THR_W'(1));
      test_response_backpressure();
      set_threshold({THR_W{1'b1}});
      run_sessions(200, 1'b1);
      set_threshold(THR_W'(2));
      run_sessions(300, 1'b1);
      set_threshold(THR_W'($urandom_range(3, 30)));
      run_sessions(300, 1'b1);
      set_threshold('0);
      test_deep_backoff();
      set_threshold(THR_W'(1));
      run_sessions(200, 1'b0);

      // drain and let the block settle
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (reports_due.size() != 0) @(posedge clock);
      repeat (LATENCY_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("event_alert_throttle_top regression: pass");
      else
         $display("event_alert_throttle_top regression: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/eat_pkg.sv
sv/event_alert_throttle_top.sv
test/event_alert_throttle_top_tb.sv
